>>> rtl/u8d_pkg.sv
// shared types, constants and helpers of the utf-8 stream decoder
package u8d_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CP_W     = 21;
    localparam int unsigned USED_W   = 3;
    localparam int unsigned HELD_N   = 3;
    localparam int unsigned Q_DEPTH  = 4;

    // bit patterns that classify a byte
    localparam logic [7:0] MASK_LEAD2 = 8'hE0;
    localparam logic [7:0] PAT_LEAD2  = 8'hC0;
    localparam logic [7:0] MASK_LEAD3 = 8'hF0;
    localparam logic [7:0] PAT_LEAD3  = 8'hE0;
    localparam logic [7:0] MASK_LEAD4 = 8'hF8;
    localparam logic [7:0] PAT_LEAD4  = 8'hF0;
    localparam logic [7:0] MASK_CONT  = 8'hC0;
    localparam logic [7:0] PAT_CONT   = 8'h80;

    localparam logic [2:0] LEN_ONE   = 3'd1;
    localparam logic [2:0] LEN_TWO   = 3'd2;
    localparam logic [2:0] LEN_THREE = 3'd3;
    localparam logic [2:0] LEN_FOUR  = 3'd4;

    // one item's worth of results: up to three flushed bytes, then at most one main entry
    typedef struct packed {
        logic [HELD_N-1:0][BYTE_W-1:0] flush_bytes;
        logic [1:0]                    flush_cnt;
        logic                          has_main;
        logic [CP_W-1:0]               main_cp;
        logic [USED_W-1:0]             main_used;
        logic                          str_end;
    } t_job;

    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        len = LEN_ONE;
        if ((b & MASK_LEAD2) == PAT_LEAD2) begin
            len = LEN_TWO;
        end else if ((b & MASK_LEAD3) == PAT_LEAD3) begin
            len = LEN_THREE;
        end else if ((b & MASK_LEAD4) == PAT_LEAD4) begin
            len = LEN_FOUR;
        end
        return len;
    endfunction

endpackage

>>> rtl/utf8_stream_decoder.sv
// top level of the utf-8 stream decoder: front end, job queue, back end
// the results of a byte pass through the job queue and the back-end registers before they are offered
// throughput: one byte per cycle while the job queue is not full; a byte that causes
//   k result items gives them out one by one, and the four-entry job queue absorbs such bursts
// bytes that only extend an open sequence cause no result item
// reset: synchronous active low; clears sequence state, the queue and the back end
module utf8_stream_decoder #(
    parameter int unsigned QDEPTH = u8d_pkg::Q_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_in
    input  logic        s_tlast,   // string_end
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [20:0] code_point, [23:21] bytes_used
    output logic        m_tuser,   // run_last
    output logic        m_tlast    // string_done
);

    localparam int unsigned LVL_W = $clog2(QDEPTH+1);

    logic                s_accept;
    logic                push;
    u8d_pkg::t_job       front_job;
    logic                q_valid;
    u8d_pkg::t_job       q_job;
    logic [LVL_W-1:0]    q_level;
    logic                pop;
    logic [20:0]         cp;
    logic [2:0]          used;

    // input side only stalls when the queue is full
    assign s_tready = q_level != LVL_W'(QDEPTH);
    assign s_accept = s_tvalid && s_tready;

    // classify the byte and decide which results it causes
    u8d_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (s_accept),
        .i_byte   (s_tdata),
        .i_end    (s_tlast),
        .o_push   (push),
        .o_job    (front_job)
    );

    // decouples byte intake from result delivery
    u8d_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (q_job),
        .o_level (q_level)
    );

    // hands out the results of each job in order
    u8d_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_job    (q_job),
        .o_pop      (pop),
        .o_valid    (m_tvalid),
        .i_ready    (m_tready),
        .o_cp       (cp),
        .o_used     (used),
        .o_run_last (m_tuser),
        .o_str_done (m_tlast)
    );

    assign m_tdata = {used, cp};

    // a string end always produces a result, so the back end is busy once its job has passed the queue
    a_end_gives_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && s_tlast |-> ##2 m_tvalid)
        else $error("string end produced no pending result");

    // the final result of a string is also the final result of its byte
    a_done_is_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tlast |-> m_tuser)
        else $error("string_done without run_last");

    // every result consumed between one and four bytes
    a_used_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (used != 3'd0) && (used <= 3'd4))
        else $error("bytes_used out of range");

    // queue never overfills
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_level <= LVL_W'(QDEPTH))
        else $error("job queue overflow");

endmodule

>>> rtl/u8d_front.sv
// front end: takes bytes, tracks the open sequence and builds result jobs
module u8d_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_byte,
    input  logic              i_end,
    output logic              o_push,
    output u8d_pkg::t_job     o_job
);

    logic [u8d_pkg::HELD_N-1:0][7:0] r_held, n_held;
    logic [1:0]                      r_count, n_count;
    logic [2:0]                      r_exp, n_exp;

    logic        is_cont;
    logic [2:0]  len;
    logic [2:0]  total;
    logic [20:0] dec_cp;

    always_comb begin
        is_cont = (i_byte & u8d_pkg::MASK_CONT) == u8d_pkg::PAT_CONT;
        len     = u8d_pkg::lead_length(i_byte);
        total   = {1'b0, r_count} + 3'd1;
        case (r_exp)
            u8d_pkg::LEN_TWO:   dec_cp = {10'd0, r_held[0][4:0], i_byte[5:0]};
            u8d_pkg::LEN_THREE: dec_cp = {5'd0, r_held[0][3:0], r_held[1][5:0], i_byte[5:0]};
            default:            dec_cp = {r_held[0][2:0], r_held[1][5:0], r_held[2][5:0],
                                          i_byte[5:0]};
        endcase
    end

    always_comb begin
        n_held = r_held;
        n_count = r_count;
        n_exp = r_exp;
        o_job.flush_bytes = r_held;
        o_job.flush_cnt = 2'd0;
        o_job.has_main = 1'b0;
        o_job.main_cp = {13'd0, i_byte};
        o_job.main_used = u8d_pkg::LEN_ONE;
        o_job.str_end = i_end;
        if (r_count != 2'd0 && is_cont) begin
            if (total == r_exp) begin
                o_job.has_main = 1'b1;
                o_job.main_cp = dec_cp;
                o_job.main_used = r_exp;
                n_count = 2'd0;
                n_exp = 3'd0;
            end else begin
                case (r_count)
                    2'd1:    n_held[1] = i_byte;
                    2'd2:    n_held[2] = i_byte;
                    default: n_held = r_held;
                endcase
                if (r_count != 2'd3) begin
                    n_count = r_count + 2'd1;
                end
                if (i_end) begin
                    // cut short at string end: every held byte goes out alone
                    o_job.flush_bytes = n_held;
                    o_job.flush_cnt = n_count;
                    n_count = 2'd0;
                    n_exp = 3'd0;
                end
            end
        end else begin
            // broken sequence (or none open): held bytes go out first
            o_job.flush_cnt = r_count;
            n_count = 2'd0;
            n_exp = 3'd0;
            if (len != u8d_pkg::LEN_ONE && !i_end) begin
                n_held[0] = i_byte;
                n_count = 2'd1;
                n_exp = len;
            end else begin
                o_job.has_main = 1'b1;
            end
        end
        o_push = i_accept && (o_job.has_main || o_job.flush_cnt != 2'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
            r_exp <= 3'd0;
        end else if (i_accept) begin
            r_count <= n_count;
            r_exp <= n_exp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_held <= n_held;
        end
    end

endmodule

>>> rtl/u8d_queue.sv
// short job queue between front and back ends
module u8d_queue #(
    parameter int unsigned DEPTH = u8d_pkg::Q_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  u8d_pkg::t_job               i_job,
    input  logic                        i_pop,
    output logic                        o_valid,
    output u8d_pkg::t_job               o_job,
    output logic [$clog2(DEPTH+1)-1:0]  o_level
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned LVL_W = $clog2(DEPTH+1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    u8d_pkg::t_job    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [LVL_W-1:0] r_level;
    logic             do_pop;

    assign o_valid = r_level != '0;
    assign o_job   = r_mem[r_rd];
    assign o_level = r_level;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_level <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + PTR_W'(1);
            end
            if (i_push && !do_pop) begin
                r_level <= r_level + LVL_W'(1);
            end else if (!i_push && do_pop) begin
                r_level <= r_level - LVL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

>>> rtl/u8d_back.sv
// back end: plays a job out as one result item per cycle while the receiver is ready
module u8d_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  u8d_pkg::t_job  i_q_job,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [20:0]    o_cp,
    output logic [2:0]     o_used,
    output logic           o_run_last,
    output logic           o_str_done
);

    u8d_pkg::t_job r_job;
    logic          r_busy, n_busy;
    logic [1:0]    r_idx, n_idx;
    logic          is_flush, is_last, fire, load;

    always_comb begin
        is_flush = r_idx < r_job.flush_cnt;
        is_last  = r_job.has_main ? (r_idx == r_job.flush_cnt)
                                  : (r_idx == r_job.flush_cnt - 2'd1);
        if (is_flush) begin
            case (r_idx)
                2'd0:    o_cp = {13'd0, r_job.flush_bytes[0]};
                2'd1:    o_cp = {13'd0, r_job.flush_bytes[1]};
                default: o_cp = {13'd0, r_job.flush_bytes[2]};
            endcase
            o_used = u8d_pkg::LEN_ONE;
        end else begin
            o_cp = r_job.main_cp;
            o_used = r_job.main_used;
        end
        o_valid    = r_busy;
        o_run_last = is_last;
        o_str_done = is_last && r_job.str_end;
        fire   = r_busy && i_ready;
        load   = !r_busy || (fire && is_last);
        o_pop  = load && i_q_valid;
        n_busy = load ? i_q_valid : r_busy;
        n_idx  = load ? 2'd0 : (fire ? r_idx + 2'd1 : r_idx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx <= 2'd0;
        end else begin
            r_busy <= n_busy;
            r_idx <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_q_job;
        end
    end

endmodule

>>> test/testbench.sv
// self-checking testbench of the utf-8 stream decoder with its own decode predictor
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned BYTE_W       = u8d_pkg::BYTE_W;
    localparam int unsigned CP_W         = u8d_pkg::CP_W;
    localparam int unsigned USED_W       = u8d_pkg::USED_W;
    localparam int unsigned HELD_N       = u8d_pkg::HELD_N;
    localparam int unsigned ITEM_TARGET  = 410;
    localparam int unsigned IDLE_LIMIT   = 2000;
    localparam int unsigned SETTLE_LEN   = 12;

    // one result item as it leaves the block
    typedef struct packed {
        logic [CP_W-1:0]   cp;
        logic [USED_W-1:0] used;
        logic              run_last;
        logic              done;
    } t_symbol;

    // decode predictor and queue of symbols still owed by the block
    class t_utf8_scoreboard;
        logic [BYTE_W-1:0] held [HELD_N];
        logic [1:0]        held_cnt;
        logic [2:0]        seq_len;
        t_symbol           owed_symbols[$];
        t_symbol           step_out[$];
        int                errors;

        function new();
            foreach (held[i]) held[i] = '0;
            held_cnt = '0;
            seq_len  = '0;
            errors   = 0;
        endfunction

        function int pending();
            return owed_symbols.size();
        endfunction

        function logic [2:0] lead_len(logic [7:0] b);
            casez (b)
                8'b110?????: return u8d_pkg::LEN_TWO;
                8'b1110????: return u8d_pkg::LEN_THREE;
                8'b11110???: return u8d_pkg::LEN_FOUR;
                default:     return u8d_pkg::LEN_ONE;
            endcase
        endfunction

        function void add_symbol(logic [CP_W-1:0] cp, logic [USED_W-1:0] used);
            t_symbol sym;
            sym = '{cp: cp, used: used, run_last: 1'b0, done: 1'b0};
            step_out = {step_out, sym};
        endfunction

        // broken or cut short: every held byte goes out alone
        function void flush_held();
            for (int i = 0; i < int'(held_cnt); i++) begin
                add_symbol(CP_W'(held[i]), u8d_pkg::LEN_ONE);
            end
            held_cnt = '0;
            seq_len  = '0;
        endfunction

        function logic [CP_W-1:0] join_sequence(logic [7:0] tail);
            case (seq_len)
                u8d_pkg::LEN_TWO:   return CP_W'({held[0][4:0], tail[5:0]});
                u8d_pkg::LEN_THREE: return CP_W'({held[0][3:0], held[1][5:0], tail[5:0]});
                default:   return {held[0][2:0], held[1][5:0], held[2][5:0], tail[5:0]};
            endcase
        endfunction

        function void note_byte(logic [7:0] b, logic str_end);
            bit         taken;
            logic [2:0] len;
            taken = 1'b0;
            step_out.delete();
            if (held_cnt != 0) begin
                if ((b & u8d_pkg::MASK_CONT) == u8d_pkg::PAT_CONT) begin
                    if (int'(held_cnt) + 1 == int'(seq_len)) begin
                        add_symbol(join_sequence(b), seq_len);
                        held_cnt = '0;
                        seq_len  = '0;
                    end else if (held_cnt < 2'd3) begin
                        held[held_cnt] = b;
                        held_cnt++;
                    end
                    taken = 1'b1;
                end else begin
                    flush_held();
                end
            end
            if (!taken) begin
                len = lead_len(b);
                if (len != u8d_pkg::LEN_ONE) begin
                    held[0]  = b;
                    held_cnt = 2'd1;
                    seq_len  = len;
                end else begin
                    add_symbol(CP_W'(b), u8d_pkg::LEN_ONE);
                end
            end
            if (str_end && held_cnt != 0) flush_held();
            if (step_out.size() > 0) begin
                step_out[step_out.size()-1].run_last = 1'b1;
                step_out[step_out.size()-1].done     = str_end;
            end
            owed_symbols = {owed_symbols, step_out};
        endfunction

        function void check_symbol(t_symbol got);
            t_symbol want;
            if (owed_symbols.size() == 0) begin
                $error("unexpected result item: code_point %h bytes_used %0d",
                       got.cp, got.used);
                errors++;
                return;
            end
            want = owed_symbols.pop_front();
            if (got.cp !== want.cp) begin
                $error("code_point: expected %h, got %h", want.cp, got.cp);
                errors++;
            end
            if (got.used !== want.used) begin
                $error("bytes_used: expected %0d, got %0d", want.used, got.used);
                errors++;
            end
            if (got.run_last !== want.run_last) begin
                $error("run_last: expected %b, got %b", want.run_last, got.run_last);
                errors++;
            end
            if (got.done !== want.done) begin
                $error("string_done: expected %b, got %b", want.done, got.done);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;   // [7:0] byte_in
    logic        s_tlast  = 1'b0; // string_end
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;         // [20:0] code_point, [23:21] bytes_used
    logic        m_tuser;         // run_last
    logic        m_tlast;         // string_done

    t_utf8_scoreboard sb = new();
    bit             calm = 1'b0;   // no idling on either side while set
    int             sent_items = 0;
    int             idle_cycles = 0;
    int             stall_left = 0;

    utf8_stream_decoder i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // sample both handshakes on the edge, input first
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_tvalid && s_tready) sb.note_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                sb.check_symbol('{cp: m_tdata[20:0], used: m_tdata[23:21],
                                  run_last: m_tuser, done: m_tlast});
            end
        end
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 99) < 25) begin
            stall_left = pick_gap();
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ends a hung run
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // present one byte and hold it until taken
    task automatic send_byte(input logic [7:0] b, input logic str_end);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= str_end;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        sent_items++;
    endtask

    // stop sending until every owed symbol has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] lead_of(int len);
        logic [7:0] r;
        r = 8'($urandom);
        case (len)
            2:       return {3'b110, r[4:0]};
            3:       return {4'b1110, r[3:0]};
            4:       return {5'b11110, r[2:0]};
            default: return {1'b0, r[6:0]};
        endcase
    endfunction

    function automatic logic [7:0] cont_byte();
        logic [7:0] r;
        r = 8'($urandom);
        return {2'b10, r[5:0]};
    endfunction

    function automatic logic end_roll();
        return $urandom_range(0, 5) == 0;
    endfunction

    task automatic send_well_formed();
        int len;
        len = $urandom_range(1, 4);
        send_byte(lead_of(len), len == 1 && end_roll());
        for (int i = 1; i < len; i++) send_byte(cont_byte(), i == len - 1 && end_roll());
    endtask

    // sequence broken by a foreign byte or cut short by the string end
    task automatic send_broken();
        int         len;
        int         k;
        bit         cut;
        logic [7:0] b;
        len = $urandom_range(2, 4);
        k   = $urandom_range(0, len - 2);
        cut = $urandom_range(0, 1);
        send_byte(lead_of(len), cut && k == 0);
        for (int i = 1; i <= k; i++) send_byte(cont_byte(), cut && i == k);
        if (!cut) begin
            do b = 8'($urandom); while ((b & u8d_pkg::MASK_CONT) == u8d_pkg::PAT_CONT);
            send_byte(b, end_roll());
        end
    endtask

    initial begin
        int chunk;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // plain bytes at the edges, including a lone continuation
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hF8, 1'b0);
        send_byte(8'hBF, 1'b0);
        // well-formed 2, 3 and 4 byte forms, the last one at its maximum
        send_byte(8'hC2, 1'b0);
        send_byte(8'hA9, 1'b0);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'hAC, 1'b0);
        send_byte(8'hF7, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        // broken by ascii, then broken by a new lead that completes
        send_byte(8'hC3, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h90, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b0);
        // string end flushing held bytes, on a lone lead, on a plain byte
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b1);
        send_byte(8'hF0, 1'b1);
        send_byte(8'h41, 1'b1);
        // broken and flushed by the same ending byte
        send_byte(8'hC0, 1'b0);
        send_byte(8'hFF, 1'b1);
        drain();

        chunk = 0;
        while (sent_items < ITEM_TARGET) begin
            calm = ($urandom_range(0, 3) == 0);
            repeat (12) begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: send_well_formed();
                    11, 12, 13, 14:                   send_broken();
                    default: send_byte(8'($urandom_range(0, 255)),
                                       $urandom_range(0, 7) == 0);
                endcase
            end
            if (chunk == 3 || $urandom_range(0, 4) == 0) drain();
            chunk++;
        end
        calm = 1'b0;

        drain();
        repeat (SETTLE_LEN) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            if (sb.pending() != 0) $error("%0d result items never arrived", sb.pending());
            $display("simulation failed");
        end
        $finish;
    end
endmodule

>>> filelist.f
rtl/u8d_pkg.sv
rtl/u8d_front.sv
rtl/u8d_queue.sv
rtl/u8d_back.sv
rtl/utf8_stream_decoder.sv
test/testbench.sv
